/* src/u8dc_pkg.sv */
package u8dc_pkg;

  localparam int CP_W     = 21;
  localparam int BYTE_W   = 8;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;

  localparam logic [CP_W-1:0] UPPER_A    = 21'h41;
  localparam logic [CP_W-1:0] UPPER_Z    = 21'h5A;
  localparam logic [CP_W-1:0] LOWER_A    = 21'h61;
  localparam logic [CP_W-1:0] LOWER_Z    = 21'h7A;
  localparam logic [CP_W-1:0] DIGIT_0    = 21'h30;
  localparam logic [CP_W-1:0] DIGIT_9    = 21'h39;
  localparam logic [CP_W-1:0] CASE_SHIFT = 21'h20;

  localparam logic [CP_W-1:0] HANGUL_SYL_LO = 21'hAC00;
  localparam logic [CP_W-1:0] HANGUL_SYL_HI = 21'hD7A3;
  localparam logic [CP_W-1:0] JAMO_LO       = 21'h1100;
  localparam logic [CP_W-1:0] JAMO_HI       = 21'h11FF;
  localparam logic [CP_W-1:0] COMPAT_LO     = 21'h3130;
  localparam logic [CP_W-1:0] COMPAT_HI     = 21'h318F;
  localparam logic [CP_W-1:0] JAMO_EXT_A_LO = 21'hA960;
  localparam logic [CP_W-1:0] JAMO_EXT_A_HI = 21'hA97F;
  localparam logic [CP_W-1:0] JAMO_EXT_B_LO = 21'hD7B0;
  localparam logic [CP_W-1:0] JAMO_EXT_B_HI = 21'hD7FF;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_HANGUL = 2'd1,
    CLS_LETTER = 2'd2,
    CLS_DIGIT  = 2'd3
  } char_class_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [CP_W-1:0] lowered_point;
    logic [1:0]      char_class;
    logic            run_last;
  } res_t;

  // Up to two results leave the decoder for each byte.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } dec_out_t;

  function automatic logic in_range(input logic [CP_W-1:0] cp,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
    in_range = (cp >= lo) && (cp <= hi);
  endfunction

  function automatic char_class_t classify(input logic [CP_W-1:0] cp);
    char_class_t cls;
    if (in_range(cp, HANGUL_SYL_LO, HANGUL_SYL_HI) || in_range(cp, JAMO_LO, JAMO_HI) ||
        in_range(cp, COMPAT_LO, COMPAT_HI) || in_range(cp, JAMO_EXT_A_LO, JAMO_EXT_A_HI) ||
        in_range(cp, JAMO_EXT_B_LO, JAMO_EXT_B_HI)) begin
      cls = CLS_HANGUL;
    end else if (in_range(cp, LOWER_A, LOWER_Z) || in_range(cp, UPPER_A, UPPER_Z)) begin
      cls = CLS_LETTER;
    end else if (in_range(cp, DIGIT_0, DIGIT_9)) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  function automatic res_t make_result(input logic [CP_W-1:0] cp);
    res_t r;
    r.code_point    = cp;
    r.lowered_point = in_range(cp, UPPER_A, UPPER_Z) ? cp + CASE_SHIFT : cp;
    r.char_class    = classify(cp);
    r.run_last      = 1'b0;
    return r;
  endfunction

  function automatic logic is_ascii(input logic [BYTE_W-1:0] b);
    is_ascii = b < ASCII_LIMIT;
  endfunction

endpackage

/* src/u8dc_in_if.sv */
interface u8dc_in_if;
  import u8dc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/u8dc_out_if.sv */
interface u8dc_out_if;
  import u8dc_pkg::*;

  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic [CP_W-1:0] lowered_point;
  logic [1:0]      char_class;
  logic            run_last;

  modport source (output valid, output code_point, output lowered_point,
                  output char_class, output run_last, input ready);
  modport sink (input valid, input code_point, input lowered_point,
                input char_class, input run_last, output ready);
endinterface

/* src/utf8_decode_classify.sv */
// Lenient UTF-8 decoder: one text byte per beat in, one codepoint per beat out, with its
// ASCII-lowercased form and a class (other, Hangul, ASCII letter, ASCII digit). A byte is
// held in an input register and, once the result queue has room, decoded into a
// four-entry result queue whose head drives the output. The block sustains one byte per
// cycle while the result queue has room; a byte that ends the text inside a multi-byte
// sequence can cause two results. Input ready drops only while the result queue has
// fewer than two free entries.
module utf8_decode_classify (
  input  logic       clk,
  input  logic       rst_n,
  u8dc_in_if.sink    in_ch,
  u8dc_out_if.source out_ch
);
  import u8dc_pkg::*;

  logic              inv_r;
  logic [BYTE_W-1:0] inb_r;
  logic              inl_r;
  logic              take;
  logic              room;
  logic              accept;
  dec_out_t          dec;

  assign take        = inv_r && room;
  assign in_ch.ready = !inv_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (accept) begin
      inv_r <= 1'b1;
    end else if (take) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inb_r <= in_ch.text_byte;
      inl_r <= in_ch.end_of_text;
    end
  end

  u8dc_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (inb_r),
    .last_in (inl_r),
    .dec     (dec)
  );

  u8dc_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (dec),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

/* src/u8dc_decode.sv */
module u8dc_decode (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [u8dc_pkg::BYTE_W-1:0] byte_in,
  input  logic                     last_in,
  output u8dc_pkg::dec_out_t       dec
);
  import u8dc_pkg::*;

  logic [1:0]        need_r, need_nxt;
  logic [1:0]        taken_r, taken_nxt;
  logic [CP_W-1:0]   part_r, part_nxt;
  logic [BYTE_W-1:0] held_r;
  logic              held_we;

  logic [1:0]        taken_inc;
  logic [CP_W-1:0]   part_acc;
  logic [BYTE_W-1:0] t0;
  logic [CP_W-1:0]   pair_cp;
  res_t              r0, r1;
  logic [1:0]        cnt;

  assign taken_inc = taken_r + 2'd1;
  assign part_acc  = {part_r[CP_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};
  assign t0        = held_r;
  assign pair_cp   = {10'd0, t0[4:0], byte_in[5:0]};

  always_comb begin
    need_nxt  = need_r;
    taken_nxt = taken_r;
    part_nxt  = part_r;
    held_we   = 1'b0;
    r0        = make_result({13'd0, byte_in});
    r1        = make_result({13'd0, byte_in});
    cnt       = 2'd0;

    if (need_r == 2'd0) begin
      if (is_ascii(byte_in)) begin
        cnt = 2'd1;
      end else if (!last_in) begin
        if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
          need_nxt = 2'd1;
          part_nxt = {16'd0, byte_in[4:0]};
        end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
          need_nxt = 2'd2;
          part_nxt = {17'd0, byte_in[3:0]};
        end else if ((byte_in & LEAD4_MASK) == LEAD4_CODE) begin
          need_nxt = 2'd3;
          part_nxt = {18'd0, byte_in[2:0]};
        end
        taken_nxt = 2'd0;
      end
    end else begin
      part_nxt = part_acc;
      if (taken_inc >= need_r) begin
        r0        = make_result(part_acc);
        cnt       = 2'd1;
        need_nxt  = 2'd0;
        taken_nxt = 2'd0;
        part_nxt  = '0;
      end else if (last_in) begin
        // The text stopped short: drop the lead byte and decode the held following byte and this one.
        if (taken_inc >= 2'd2) begin
          if (is_ascii(t0)) begin
            r0 = make_result({13'd0, t0});
            if (is_ascii(byte_in)) begin
              cnt = 2'd2;
            end else begin
              cnt = 2'd1;
            end
          end else if ((t0 & LEAD2_MASK) == LEAD2_CODE) begin
            r0  = make_result(pair_cp);
            cnt = 2'd1;
          end else if (is_ascii(byte_in)) begin
            cnt = 2'd1;
          end
        end else if (is_ascii(byte_in)) begin
          cnt = 2'd1;
        end
      end else begin
        held_we   = (taken_inc == 2'd1);
        taken_nxt = taken_inc;
      end
    end

    if (last_in) begin
      need_nxt  = 2'd0;
      taken_nxt = 2'd0;
      part_nxt  = '0;
    end

    r0.run_last = (cnt == 2'd1);
    r1.run_last = 1'b1;
  end

  always_comb begin
    dec.count  = take ? cnt : 2'd0;
    dec.first  = r0;
    dec.second = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r  <= 2'd0;
      taken_r <= 2'd0;
      part_r  <= '0;
    end else if (take) begin
      need_r  <= need_nxt;
      taken_r <= taken_nxt;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_we) begin
      held_r <= byte_in;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    need_r == 2'd0 |-> (taken_r == 2'd0 && part_r == '0))
    else $error("decoder idle with sequence state left over");

  a_taken_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    need_r != 2'd0 |-> taken_r < need_r)
    else $error("sequence holds as many following bytes as it needs");

  a_pair_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    dec.count == 2'd2 |-> last_in)
    else $error("two results from a byte that does not end the text");
`endif

endmodule

/* src/u8dc_outq.sv */
module u8dc_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  u8dc_pkg::dec_out_t  push,
  output logic                room,
  u8dc_out_if.source          out_ch
);
  import u8dc_pkg::*;

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  res_t              head;

  assign head = mem[rd_r];
  assign pop  = out_ch.valid && out_ch.ready;
  // Room for the largest burst one byte can cause.
  assign room = count_r <= QCNT_W'(QDEPTH - 2);

  assign out_ch.valid         = count_r != '0;
  assign out_ch.code_point    = head.code_point;
  assign out_ch.lowered_point = head.lowered_point;
  assign out_ch.char_class    = head.char_class;
  assign out_ch.run_last      = head.run_last;

  always_comb begin
    wr_nxt    = wr_r + QPTR_W'(push.count);
    rd_nxt    = pop ? rd_r + QPTR_W'(1) : rd_r;
    count_nxt = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.count == 2'd0) |=> count_r == $past(count_r) - QCNT_W'(1))
    else $error("result queue count did not fall after a beat left");
`endif

endmodule

/* tb/utf8_decode_classify_tb.sv */
module utf8_decode_classify_tb;
  import u8dc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_BYTES = 2100;
  localparam int unsigned LONG_STALL   = 400;
  localparam int unsigned STALL_AFTER  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Codepoints on either side of the Hangul range edges, sent as 3-byte sequences.
  localparam logic [15:0] HANGUL_EDGES [19] = '{
    16'hAC00, 16'hD7A3, 16'hD7A4, 16'hABFF, 16'h1100, 16'h11FF, 16'h10FF,
    16'h1200, 16'h3130, 16'h318F, 16'h312F, 16'h3190, 16'hA960, 16'hA97F,
    16'hA95F, 16'hA980, 16'hD7B0, 16'hD7FF, 16'hD7AF
  };

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              eot;
  } text_beat_t;

  class codepoint_scoreboard;
    res_t              pending_points[$];
    int unsigned       mismatches;
    int unsigned       points_seen;
    logic [1:0]        seq_need;
    logic [1:0]        seq_got;
    logic [CP_W-1:0]   seq_bits;
    logic [BYTE_W-1:0] held[2];

    function new();
      mismatches  = 0;
      points_seen = 0;
      seq_need    = 2'd0;
      seq_got     = 2'd0;
      seq_bits    = '0;
      held[0]     = '0;
      held[1]     = '0;
    endfunction

    function char_class_t class_of(logic [CP_W-1:0] cp);
      if ((cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'h1100 && cp <= 21'h11FF) ||
          (cp >= 21'h3130 && cp <= 21'h318F) || (cp >= 21'hA960 && cp <= 21'hA97F) ||
          (cp >= 21'hD7B0 && cp <= 21'hD7FF)) begin
        return CLS_HANGUL;
      end
      if ((cp >= UPPER_A && cp <= UPPER_Z) || (cp >= LOWER_A && cp <= LOWER_Z)) begin
        return CLS_LETTER;
      end
      if (cp >= DIGIT_0 && cp <= DIGIT_9) begin
        return CLS_DIGIT;
      end
      return CLS_OTHER;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic eot);
      logic [CP_W-1:0]   found[$];
      logic [BYTE_W-1:0] tail[2];
      int                n;
      int                i;
      int unsigned       got;
      res_t              r;
      if (seq_need == 2'd0) begin
        if (b < ASCII_LIMIT) begin
          found.insert(found.size(), {13'd0, b});
        end else if (!eot) begin
          if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            seq_need = 2'd1;
            seq_bits = {16'd0, b[4:0]};
          end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            seq_need = 2'd2;
            seq_bits = {17'd0, b[3:0]};
          end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            seq_need = 2'd3;
            seq_bits = {18'd0, b[2:0]};
          end
          seq_got = 2'd0;
        end
      end else begin
        got      = seq_got + 1;
        seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
        if (got >= seq_need) begin
          found.insert(found.size(), seq_bits);
          seq_need = 2'd0;
          seq_got  = 2'd0;
          seq_bits = '0;
        end else if (eot) begin
          // The lead is dropped and the following bytes taken so far are read again
          // as a short text of their own.
          n = 0;
          if (got >= 2) begin
            tail[0] = held[0];
            n = 1;
          end
          tail[n] = b;
          n++;
          i = 0;
          while (i < n) begin
            if (tail[i] < ASCII_LIMIT) begin
              found.insert(found.size(), {13'd0, tail[i]});
              i++;
            end else if ((tail[i] & LEAD2_MASK) == LEAD2_CODE && i + 1 < n) begin
              found.insert(found.size(), {10'd0, tail[i][4:0], tail[i+1][5:0]});
              i += 2;
            end else begin
              i++;
            end
          end
        end else begin
          held[(got - 1) & 1] = b;
          seq_got = got[1:0];
        end
      end
      if (eot) begin
        seq_need = 2'd0;
        seq_got  = 2'd0;
        seq_bits = '0;
      end
      foreach (found[k]) begin
        r.code_point    = found[k];
        r.lowered_point = (found[k] >= UPPER_A && found[k] <= UPPER_Z) ?
                          found[k] + CASE_SHIFT : found[k];
        r.char_class    = class_of(found[k]);
        r.run_last      = (k == found.size() - 1);
        pending_points.insert(pending_points.size(), r);
      end
    endfunction

    function void check_point(res_t seen);
      res_t want;
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("unexpected result beat: code_point %h", seen.code_point);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      if (seen.code_point !== want.code_point) begin
        $error("code_point expected %h actual %h", want.code_point, seen.code_point);
        mismatches++;
      end
      if (seen.lowered_point !== want.lowered_point) begin
        $error("lowered_point expected %h actual %h", want.lowered_point, seen.lowered_point);
        mismatches++;
      end
      if (seen.char_class !== want.char_class) begin
        $error("char_class expected %0d actual %0d", want.char_class, seen.char_class);
        mismatches++;
      end
      if (seen.run_last !== want.run_last) begin
        $error("run_last expected %0b actual %0b", want.run_last, seen.run_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   sending_done = 1'b0;
  int unsigned cycle_count = 0;

  text_beat_t          text_stream[$];
  codepoint_scoreboard points_sb;

  u8dc_in_if  in_ch();
  u8dc_out_if out_ch();

  utf8_decode_classify u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        points_sb.note_byte(in_ch.text_byte, in_ch.end_of_text);
      end
      if (out_ch.valid && out_ch.ready) begin
        points_sb.check_point({out_ch.code_point, out_ch.lowered_point,
                               out_ch.char_class, out_ch.run_last});
      end
    end
  end

  function automatic void put(logic [BYTE_W-1:0] b, logic eot);
    text_stream.insert(text_stream.size(), {b, eot});
  endfunction

  // Following bytes keep their low six bits; now and then the top bits are scrambled,
  // which the decoder must not notice.
  function automatic void put_seq(logic [CP_W-1:0] cp, int len);
    logic [BYTE_W-1:0] lead;
    logic [1:0]        top;
    case (len)
      2: begin
        lead = {3'b110, cp[10:6]};
      end
      3: begin
        lead = {4'b1110, cp[15:12]};
      end
      default: begin
        lead = {5'b11110, cp[20:18]};
      end
    endcase
    put(lead, 1'b0);
    for (int k = len - 2; k >= 0; k--) begin
      top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
      put({top, cp[k*6 +: 6]}, 1'b0);
    end
  endfunction

  function automatic void put_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      put(8'($urandom_range(0, 127)), 1'b0);
    end else if (pick < 45) begin
      // A quarter of the 2-byte sequences are overlong forms of ASCII.
      put_seq(($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 127)) :
              21'($urandom_range(0, 12'h7FF)), 2);
    end else if (pick < 75) begin
      if ($urandom_range(0, 1) == 0) begin
        put_seq({5'd0, HANGUL_EDGES[$urandom_range(0, 18)]}, 3);
      end else if ($urandom_range(0, 2) != 0) begin
        put_seq(21'($urandom_range(16'hAC00, 16'hD7FF)), 3);
      end else begin
        put_seq(21'($urandom_range(0, 16'hFFFF)), 3);
      end
    end else if (pick < 85) begin
      put_seq(21'($urandom_range(0, 21'h1FFFFF)), 4);
    end else begin
      put(8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  // Bytes that may follow a lead when the text stops early: ASCII and 2-byte leads
  // decode again on their own.
  function automatic logic [BYTE_W-1:0] tail_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 127));
      1:       return {3'b110, 5'($urandom_range(0, 31))};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_text();
    int unsigned chars;
    int unsigned ending;
    int unsigned need;
    int unsigned follow;
    text_beat_t  last_beat;
    chars = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
    repeat (chars) put_char();
    ending = $urandom_range(0, 9);
    if (ending < 6) begin
      last_beat = text_stream.pop_back();
      last_beat.eot = 1'b1;
      text_stream.insert(text_stream.size(), last_beat);
    end else if (ending < 8) begin
      need = $urandom_range(2, 3);
      put((need == 2) ? {4'b1110, 4'($urandom_range(0, 15))} :
                        {5'b11110, 3'($urandom_range(0, 7))}, 1'b0);
      follow = $urandom_range(1, need - 1);
      repeat (follow - 1) put(tail_byte(), 1'b0);
      put(tail_byte(), 1'b1);
    end else if (ending < 9) begin
      put(8'($urandom_range(8'hC0, 8'hF7)), 1'b1);
    end
    // Otherwise the text runs on into the next one.
  endfunction

  task automatic send_bytes();
    int unsigned gap;
    bit          calm;
    calm = 1'b0;
    foreach (text_stream[i]) begin
      if (i % 48 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.text_byte   <= text_stream[i].text_byte;
      in_ch.end_of_text <= text_stream[i].eot;
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic take_points();
    int unsigned hold;
    int unsigned beats;
    bit          calm;
    bit          squeezed;
    beats    = 0;
    calm     = 1'b0;
    squeezed = 1'b0;
    forever begin
      if (beats % 64 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      hold = calm ? 0 : $urandom_range(0, 13);
      // One long hold-off lets the result queue fill so that the input stalls.
      if (!squeezed && points_sb.points_seen >= STALL_AFTER) begin
        squeezed = 1'b1;
        hold = LONG_STALL;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      beats++;
    end
  endtask

  initial begin
    points_sb = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    out_ch.ready      <= 1'b0;

    // ASCII extremes and the other, letter and digit classes, the text ending on a plain byte.
    put(8'h00, 1'b0);
    put(8'h7F, 1'b0);
    put(8'h41, 1'b0);
    put(8'h5A, 1'b0);
    put(8'h30, 1'b0);
    put(8'h39, 1'b1);
    // Stray bytes with no sequence open.
    put(8'h80, 1'b0);
    put(8'hFF, 1'b0);
    // Largest 2-byte codepoint, first Hangul syllable.
    put(8'hDF, 1'b0);
    put(8'hBF, 1'b0);
    put(8'hEA, 1'b0);
    put(8'hB0, 1'b0);
    put(8'h80, 1'b0);
    // Largest 4-byte pattern, completed on the last byte of the text.
    put(8'hF7, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b1);
    // A lead as the last byte is skipped.
    put(8'hC2, 1'b1);
    // Texts cut short inside a sequence: two, one and no results from the tail.
    put(8'hF0, 1'b0);
    put(8'h41, 1'b0);
    put(8'h42, 1'b1);
    put(8'hF0, 1'b0);
    put(8'hC3, 1'b0);
    put(8'hA9, 1'b1);
    put(8'hE0, 1'b0);
    put(8'h80, 1'b1);

    while (text_stream.size() < RANDOM_BYTES) put_text();
    put(8'h20, 1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      begin
        send_bytes();
        sending_done = 1'b1;
      end
      take_points();
    join_none

    wait (sending_done);
    // The last beat is noted by the monitor at the same edge, so wait for the next edge.
    @(posedge clk);
    while (points_sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (points_sb.mismatches == 0 && points_sb.pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
